/* design/lz77hw_pkg.sv */
`default_nettype none

package lz77hw_pkg;

  localparam int WINDOW_BYTES = 65536;
  localparam int WPOS_W       = $clog2(WINDOW_BYTES);
  localparam int FILL_W       = $clog2(WINDOW_BYTES + 1);
  // Wide enough for the distance field, the fill count and position sums.
  localparam int CMP_W        = 17;

  localparam int LIT_W        = 8;
  localparam int LEN_W        = 9;
  localparam int DIST_W       = 16;
  localparam int BYTES_W      = 64;
  localparam int CNT_W        = 4;

  localparam int LIT_LSB      = 0;
  localparam int LEN_LSB      = LIT_LSB + LIT_W;
  localparam int DIST_LSB     = LEN_LSB + LEN_W;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 72;

  localparam logic [LEN_W-1:0] MAX_COPY   = 9'd258;
  localparam logic [CNT_W-1:0] WORD_BYTES = 4'd8;

  localparam logic REQ_LITERAL = 1'b0;
  localparam logic REQ_MATCH   = 1'b1;

  typedef struct packed {
    logic take_lit;
    logic take_err;
    logic start_copy;
    logic issue;
    logic push_live;
    logic push_hold;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad_dist;
    logic len_zero;
    logic can_issue;
    logic word_done;
    logic final_byte;
    logic out_free;
  } dp_stat_t;

  function automatic logic [WPOS_W-1:0] next_slot(input logic [WPOS_W-1:0] p);
    return (p == WPOS_W'(WINDOW_BYTES - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

/* design/lz77hw_ram.sv */
`default_nettype none

module lz77hw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* design/lz77hw_ctrl.sv */
`default_nettype none

module lz77hw_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  req_type,
  input  wire lz77hw_pkg::dp_stat_t  stat,
  output logic                       in_tready,
  output lz77hw_pkg::ctrl_cmd_t      cmd
);

  import lz77hw_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_COPY = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE) && stat.out_free;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_LITERAL) begin
            cmd.take_lit = 1'b1;
          end else if (stat.bad_dist || stat.len_zero) begin
            cmd.take_err = 1'b1;
          end else begin
            cmd.start_copy = 1'b1;
            state_nxt      = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        cmd.issue = stat.can_issue;
        if (stat.word_done) begin
          if (stat.out_free) begin
            cmd.push_live = 1'b1;
            if (stat.final_byte) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (stat.out_free) begin
          cmd.push_hold = 1'b1;
          state_nxt     = stat.final_byte ? ST_IDLE : ST_COPY;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lz77hw_dp.sv */
`default_nettype none

module lz77hw_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [lz77hw_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire lz77hw_pkg::ctrl_cmd_t                  cmd,
  input  wire logic                                   out_tready,
  output lz77hw_pkg::dp_stat_t                        stat,
  output logic                                        out_tvalid,
  output logic      [lz77hw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                        out_tlast,
  output logic      [0:0]                             out_tuser
);

  import lz77hw_pkg::*;

  logic [LIT_W-1:0]   lit;
  logic [LEN_W-1:0]   len;
  logic [DIST_W-1:0]  match_dist;
  logic [LEN_W-1:0]   len_sat;
  logic [CMP_W-1:0]   src_wide;
  logic [WPOS_W-1:0]  src_start;

  logic [WPOS_W-1:0]  wr_pos_r, wr_pos_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [WPOS_W-1:0]  src_r;
  logic [LEN_W-1:0]   remain_r;
  logic [CNT_W-1:0]   iss_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BYTES_W-1:0] word_r, word_nxt;
  logic               rd_pend_r;
  logic               fwd_r;
  logic [LIT_W-1:0]   fwd_byte_r;
  logic [LIT_W-1:0]   ram_q;
  logic [LIT_W-1:0]   arr_byte;
  logic               ram_we;
  logic [LIT_W-1:0]   ram_wdata;

  logic               out_valid_r;
  logic [BYTES_W-1:0] out_bytes_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_last_r;
  logic               out_bad_r;
  logic               out_load;

  assign lit        = in_tdata[LIT_LSB +: LIT_W];
  assign len        = in_tdata[LEN_LSB +: LEN_W];
  assign match_dist = in_tdata[DIST_LSB +: DIST_W];

  assign len_sat = (len > MAX_COPY) ? MAX_COPY : len;

  // Copy start lies match_dist bytes behind the write position, wrapping around.
  assign src_wide  = CMP_W'(wr_pos_r) + CMP_W'(WINDOW_BYTES) - CMP_W'(match_dist);
  assign src_start = (src_wide >= CMP_W'(WINDOW_BYTES))
                   ? WPOS_W'(src_wide - CMP_W'(WINDOW_BYTES))
                   : WPOS_W'(src_wide);

  assign stat.bad_dist   = (match_dist == '0) || (CMP_W'(match_dist) > CMP_W'(fill_r))
                        || (CMP_W'(match_dist) > CMP_W'(WINDOW_BYTES - 1));
  assign stat.len_zero   = (len == '0);
  assign stat.can_issue  = (remain_r != '0) && (iss_r != WORD_BYTES);
  assign stat.word_done  = rd_pend_r
                        && ((cnt_r == WORD_BYTES - 1'b1) || (remain_r == '0));
  assign stat.final_byte = (remain_r == '0);
  assign stat.out_free   = !out_valid_r || out_tready;

  // When a read hits the slot written in the same cycle, the written byte
  // is forwarded instead of the stale memory contents.
  assign arr_byte  = fwd_r ? fwd_byte_r : ram_q;
  assign ram_we    = cmd.take_lit || rd_pend_r;
  assign ram_wdata = cmd.take_lit ? lit : arr_byte;

  lz77hw_ram #(
    .WIDTH (LIT_W),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos_r),
    .wdata (ram_wdata),
    .re    (cmd.issue),
    .raddr (src_r),
    .rdata (ram_q)
  );

  always_comb begin
    wr_pos_nxt = wr_pos_r;
    fill_nxt   = fill_r;
    if (ram_we) begin
      wr_pos_nxt = next_slot(wr_pos_r);
      if (fill_r != FILL_W'(WINDOW_BYTES)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  assign word_nxt = word_r | (BYTES_W'(arr_byte) << {cnt_r[2:0], 3'b000});
  assign cnt_nxt  = cnt_r + 1'b1;
  assign out_load = cmd.take_lit || cmd.take_err || cmd.push_live || cmd.push_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      fill_r      <= '0;
      remain_r    <= '0;
      iss_r       <= '0;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_pos_r  <= wr_pos_nxt;
      fill_r    <= fill_nxt;
      rd_pend_r <= cmd.issue;
      fwd_r     <= cmd.issue && rd_pend_r && (src_r == wr_pos_r);
      if (cmd.start_copy) begin
        remain_r <= len_sat;
        iss_r    <= '0;
        cnt_r    <= '0;
      end else if (cmd.push_live || cmd.push_hold) begin
        iss_r <= '0;
        cnt_r <= '0;
      end else begin
        if (cmd.issue) begin
          remain_r <= remain_r - 1'b1;
          iss_r    <= iss_r + 1'b1;
        end
        if (rd_pend_r) begin
          cnt_r <= cnt_nxt;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_copy) begin
      src_r <= src_start;
    end else if (cmd.issue) begin
      src_r <= next_slot(src_r);
    end
    if (rd_pend_r) begin
      fwd_byte_r <= arr_byte;
    end
    if (cmd.start_copy || cmd.push_live || cmd.push_hold) begin
      word_r <= '0;
    end else if (rd_pend_r) begin
      word_r <= word_nxt;
    end
    if (cmd.take_lit) begin
      out_bytes_r <= BYTES_W'(lit);
      out_cnt_r   <= CNT_W'(1);
      out_last_r  <= 1'b1;
      out_bad_r   <= 1'b0;
    end else if (cmd.take_err) begin
      out_bytes_r <= '0;
      out_cnt_r   <= '0;
      out_last_r  <= 1'b1;
      out_bad_r   <= stat.bad_dist;
    end else if (cmd.push_live) begin
      out_bytes_r <= word_nxt;
      out_cnt_r   <= cnt_nxt;
      out_last_r  <= stat.final_byte;
      out_bad_r   <= 1'b0;
    end else if (cmd.push_hold) begin
      out_bytes_r <= word_r;
      out_cnt_r   <= cnt_r;
      out_last_r  <= stat.final_byte;
      out_bad_r   <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {{(OUT_TDATA_W - BYTES_W - CNT_W){1'b0}}, out_cnt_r, out_bytes_r};
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_bad_r;

endmodule

`default_nettype wire

/* design/lz77_history_window_copy.sv */
// A literal, a rejected match and an empty match give one result in the cycle after accept.
// A match of L bytes reads one history byte per cycle through the single read port of the
// history RAM, pausing while each eight-byte result is handed on and while the output is
// stalled; the next request is taken only after the last result of the match is handed on.
// Reset (synchronous, rst_n low) clears write position, fill count and control state;
// the history RAM is not cleared and needs no clearing pass.
`default_nettype none

module lz77_history_window_copy (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // Fields from bit 0: literal_byte[7:0], match_length[16:8], match_distance[32:17].
  input  wire logic [lz77hw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Fields from bit 0: req_type.
  input  wire logic [0:0]                            in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // Fields from bit 0: out_bytes[63:0], byte_count[67:64].
  output logic      [lz77hw_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                       out_tlast,
  // Fields from bit 0: bad_distance.
  output logic      [0:0]                            out_tuser
);

  import lz77hw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lz77hw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .req_type  (in_tuser[0]),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  lz77hw_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .out_tready (out_tready),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // A request is only taken when the output register can take its result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("request accepted while a result is stalled");

  // A rejected match carries no bytes and closes the item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tlast && (out_tdata[67:64] == '0)))
    else $error("bad distance result with bytes or without last");

  // Only the final result of an item may be short.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[67:64] != WORD_BYTES)) |-> out_tlast)
    else $error("short result before the end of an item");

  // A result never claims more than eight bytes.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[67:64] <= WORD_BYTES))
    else $error("byte count above eight");

endmodule

`default_nettype wire

/* tb/tb_lz77_history_window_copy.sv */
`timescale 1ns / 100ps

module tb_lz77_history_window_copy;
  import lz77hw_pkg::*;

  localparam int RANDOM_REQUESTS = 389;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic [BYTES_W-1:0] bytes;
    logic [CNT_W-1:0]   count;
    logic               last;
    logic               bad;
  } copy_word_t;

  // Tracks the history window and the words every accepted request must produce.
  class history_copy_board;
    logic [LIT_W-1:0]  window_mem [WINDOW_BYTES];
    logic [WPOS_W-1:0] wpos;
    int unsigned       fill;
    copy_word_t        expected_words[$];
    int unsigned       errors;

    function new();
      wpos   = '0;
      fill   = 0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    function void push_word(logic [BYTES_W-1:0] bytes, int unsigned count, logic last,
                            logic bad);
      copy_word_t w;
      w.bytes = bytes;
      w.count = CNT_W'(count);
      w.last  = last;
      w.bad   = bad;
      expected_words.push_back(w);
    endfunction

    function void append_byte(logic [LIT_W-1:0] b);
      window_mem[wpos] = b;
      wpos = wpos + 1'b1;
      if (fill < WINDOW_BYTES)
        fill++;
    endfunction

    function void note_request(logic req, logic [LIT_W-1:0] lit, logic [LEN_W-1:0] len,
                               logic [DIST_W-1:0] match_dist);
      int unsigned        n;
      int unsigned        k;
      logic [WPOS_W-1:0]  src;
      logic [LIT_W-1:0]   b;
      logic [BYTES_W-1:0] word;
      if (req == REQ_LITERAL) begin
        append_byte(lit);
        push_word(BYTES_W'(lit), 1, 1'b1, 1'b0);
        return;
      end
      if (match_dist == 0 || match_dist > fill || match_dist > WINDOW_BYTES - 1) begin
        push_word('0, 0, 1'b1, 1'b1);
        return;
      end
      n = (len > MAX_COPY) ? MAX_COPY : len;
      if (n == 0) begin
        push_word('0, 0, 1'b1, 1'b0);
        return;
      end
      // The window is a power of two, so the position arithmetic wraps by itself.
      src  = wpos - match_dist;
      word = '0;
      k    = 0;
      for (int i = 0; i < n; i++) begin
        b = window_mem[src];
        append_byte(b);
        src = src + 1'b1;
        word[8*k +: 8] = b;
        k++;
        if (k == 8 || i == n - 1) begin
          push_word(word, k, i == n - 1, 1'b0);
          word = '0;
          k    = 0;
        end
      end
    endfunction

    function void check_result(logic [BYTES_W-1:0] bytes, logic [CNT_W-1:0] count,
                               logic last, logic bad);
      copy_word_t e;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result bytes=%h count=%0d last=%b bad=%b",
                   $realtime, bytes, count, last, bad);
        return;
      end
      e = expected_words.pop_front();
      if (bytes !== e.bytes || count !== e.count || last !== e.last || bad !== e.bad) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                   $realtime, e.bytes, e.count, e.last, e.bad, bytes, count, last, bad);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [0:0]             in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [0:0]             out_tuser;

  history_copy_board books;

  lz77_history_window_copy dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DIST_W-1:0] good_distance(int unsigned fill);
    int unsigned reach;
    int unsigned r;
    reach = (fill > WINDOW_BYTES - 1) ? WINDOW_BYTES - 1 : fill;
    r = $urandom_range(0, 99);
    if (r < 35)
      return DIST_W'($urandom_range(1, (reach < 8) ? reach : 8));
    if (r < 50)
      return DIST_W'(reach);
    return DIST_W'($urandom_range(1, reach));
  endfunction

  task automatic send_request(input logic req, input logic [LIT_W-1:0] lit,
                              input logic [LEN_W-1:0] len,
                              input logic [DIST_W-1:0] match_dist);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= IN_TDATA_W'({match_dist, len, lit});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    books.note_request(req, lit, len, match_dist);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (books.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      books.check_result(out_tdata[BYTES_W-1:0], out_tdata[BYTES_W +: CNT_W], out_tlast,
                         out_tuser[0]);
  end

  initial begin
    int unsigned gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      gap = idle_len();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned fill;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] match_dist;
    books = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_LITERAL;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty history, ignored fields, overlap, length edges, distance edges.
    send_request(REQ_MATCH,   8'h00, 9'd3,   16'd1);
    send_request(REQ_MATCH,   8'h00, 9'd0,   16'd0);
    send_request(REQ_LITERAL, 8'h00, 9'h1FF, 16'hFFFF);
    send_request(REQ_LITERAL, 8'hFF, 9'd0,   16'd0);
    send_request(REQ_LITERAL, 8'h5A, 9'd258, 16'd2);
    send_request(REQ_MATCH,   8'hFF, 9'd3,   DIST_W'(books.fill));
    send_request(REQ_MATCH,   8'h00, 9'd20,  16'd1);
    send_request(REQ_MATCH,   8'h00, 9'd258, 16'd0);
    send_request(REQ_MATCH,   8'h00, 9'd3,   DIST_W'(books.fill + 1));
    send_request(REQ_MATCH,   8'h00, 9'h1FF, 16'hFFFF);
    send_request(REQ_MATCH,   8'h00, 9'd0,   16'd2);
    send_request(REQ_MATCH,   8'h00, 9'd1,   16'd5);
    send_request(REQ_MATCH,   8'h00, 9'd2,   16'd4);
    send_request(REQ_MATCH,   8'hA5, 9'h1FF, 16'd7);
    send_request(REQ_MATCH,   8'h00, 9'd259, 16'd26);
    send_request(REQ_MATCH,   8'h00, 9'd258, DIST_W'(books.fill));
    send_request(REQ_MATCH,   8'h00, 9'd258, 16'd9);
    send_request(REQ_LITERAL, 8'h80, 9'd0,   16'd0);
    send_request(REQ_MATCH,   8'h00, 9'd9,   16'd1);
    send_request(REQ_MATCH,   8'h00, 9'd8,   16'd8);
    send_request(REQ_MATCH,   8'h00, 9'd16,  16'd8);
    hold_until_drained();

    // Random part: mostly valid matches, with literals, rejects and odd lengths mixed in.
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      fill = books.fill;
      r = $urandom_range(0, 99);
      if (r < 12 || fill == 0) begin
        send_request(REQ_LITERAL, LIT_W'($urandom_range(0, 255)),
                     LEN_W'($urandom_range(0, 511)), DIST_W'($urandom));
      end else if (r < 20) begin
        if (fill < WINDOW_BYTES - 1 && $urandom_range(0, 3) != 0)
          match_dist = DIST_W'($urandom_range(fill + 1, WINDOW_BYTES - 1));
        else
          match_dist = '0;
        send_request(REQ_MATCH, LIT_W'($urandom_range(0, 255)),
                     LEN_W'($urandom_range(0, 511)), match_dist);
      end else if (r < 25) begin
        case ($urandom_range(0, 3))
          0: len = 9'd0;
          1: len = 9'd1;
          2: len = 9'd2;
          default: len = LEN_W'($urandom_range(259, 511));
        endcase
        send_request(REQ_MATCH, LIT_W'($urandom_range(0, 255)), len, good_distance(fill));
      end else begin
        len = ($urandom_range(0, 9) < 7) ? MAX_COPY : LEN_W'($urandom_range(3, 257));
        send_request(REQ_MATCH, LIT_W'($urandom_range(0, 255)), len, good_distance(fill));
      end
      if (i % 97 == 50)
        hold_until_drained();
    end

    in_tvalid <= 1'b0;
    while (books.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (books.errors == 0 && books.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
